>>> design/cpv_pkg.sv
// Shared types, widths and constants of the polygon vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package cpv_pkg;

  localparam int IDX_W     = 11;  // vertex index
  localparam int NS_W      = 11;  // side count register
  localparam int RAD_W     = 16;  // radius, unsigned Q8.8
  localparam int COORD_W   = 16;  // coordinates, signed Q7.8
  localparam int PH_W      = 16;  // phase, 2^16 per turn
  localparam int XY_W      = 32;  // rotator x/y, Q2.30
  localparam int Z_W       = 32;  // residual angle, 2^32 per turn
  localparam int UNIT_FRAC = 30;  // fraction bits of the unit vector
  localparam int ATAN_N    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam int MAX_SIDES_DEF     = 1024;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDES    = 2'd3;

  localparam logic [RAD_W-1:0]          RADIUS_RST = 16'd256;
  localparam logic signed [COORD_W-1:0] CENTER_RST = 16'sd0;
  localparam logic [NS_W-1:0]           SIDES_RST  = 11'd32;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // 1/gain of the rotator in Q2.30
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // atan(2^-k) in turns scaled by 2^32
  localparam logic [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic rim;  // rim vertex, goes through the rotator
    logic oor;  // index beyond side count
  } cpv_tag_t;

  typedef struct packed {
    cpv_tag_t        tag;
    logic [NS_W-1:0] rem;
    logic [PH_W-1:0] quo;
  } cpv_div_t;

  typedef struct packed {
    cpv_tag_t               tag;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cpv_rot_t;

  typedef struct packed {
    logic                      sat;
    logic                      oor;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] px;
  } cpv_res_t;

endpackage
`default_nettype wire

>>> design/cpv_div_cell.sv
// One quotient bit of the pipelined phase divider.
`timescale 1ns / 1ps
`default_nettype none
module cpv_div_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_vld,
  input  wire cpv_pkg::cpv_div_t         in_s,
  input  wire logic [cpv_pkg::NS_W-1:0]  divisor,
  output logic                           out_vld,
  output cpv_pkg::cpv_div_t              out_s
);

  logic              vld_r;
  cpv_pkg::cpv_div_t s_r;
  cpv_pkg::cpv_div_t s_nxt;
  logic [cpv_pkg::NS_W:0] rem2;
  logic [cpv_pkg::NS_W:0] diff;
  logic                   ge;

  // shift the remainder up and try one subtract of the divisor
  always_comb begin
    rem2  = {in_s.rem, 1'b0};
    diff  = rem2 - {1'b0, divisor};
    ge    = (rem2 >= {1'b0, divisor});
    s_nxt = in_s;
    s_nxt.rem = ge ? diff[cpv_pkg::NS_W-1:0] : rem2[cpv_pkg::NS_W-1:0];
    s_nxt.quo = {in_s.quo[cpv_pkg::PH_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_s   = s_r;

endmodule
`default_nettype wire

>>> design/cpv_cordic_cell.sv
// One micro-rotation of the sine/cosine rotator.
`timescale 1ns / 1ps
`default_nettype none
module cpv_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire cpv_pkg::cpv_rot_t  in_s,
  output logic                    out_vld,
  output cpv_pkg::cpv_rot_t       out_s
);

  localparam logic signed [cpv_pkg::Z_W-1:0] ANGLE = $signed(cpv_pkg::ATAN_TAB[STAGE]);

  logic              vld_r;
  cpv_pkg::cpv_rot_t s_r;
  cpv_pkg::cpv_rot_t s_nxt;
  logic signed [cpv_pkg::XY_W-1:0] x;
  logic signed [cpv_pkg::XY_W-1:0] y;
  logic signed [cpv_pkg::XY_W-1:0] dx;
  logic signed [cpv_pkg::XY_W-1:0] dy;
  logic signed [cpv_pkg::Z_W-1:0]  z;

  always_comb begin
    x  = in_s.x;
    y  = in_s.y;
    z  = in_s.z;
    dx = y >>> STAGE;
    dy = x >>> STAGE;
    s_nxt = in_s;
    // rotate towards zero residual angle
    if (!z[cpv_pkg::Z_W-1]) begin
      s_nxt.x = x - dx;
      s_nxt.y = y + dy;
      s_nxt.z = z - ANGLE;
    end else begin
      s_nxt.x = x + dx;
      s_nxt.y = y - dy;
      s_nxt.z = z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_s   = s_r;

endmodule
`default_nettype wire

>>> design/cpv_place.sv
// Scale a unit vector component by the radius, round, offset and saturate.
`timescale 1ns / 1ps
`default_nettype none
module cpv_place (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [cpv_pkg::XY_W-1:0]     unit,
  input  wire logic [cpv_pkg::RAD_W-1:0]           radius,
  input  wire logic signed [cpv_pkg::COORD_W-1:0]  center,
  output logic signed [cpv_pkg::COORD_W-1:0]       coord,
  output logic                                     sat
);

  localparam int PW = cpv_pkg::RAD_W + cpv_pkg::XY_W + 1;
  localparam int OW = PW - cpv_pkg::UNIT_FRAC;
  localparam int SW = OW + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (cpv_pkg::UNIT_FRAC - 1);
  localparam logic signed [SW-1:0] CMAX = SW'((1 << (cpv_pkg::COORD_W - 1)) - 1);
  localparam logic signed [SW-1:0] CMIN = SW'(-(1 << (cpv_pkg::COORD_W - 1)));

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] rnd;
  logic signed [OW-1:0] off;
  logic signed [SW-1:0] sum;
  logic signed [cpv_pkg::COORD_W-1:0] coord_r;
  logic signed [cpv_pkg::COORD_W-1:0] coord_nxt;
  logic sat_r;
  logic sat_nxt;

  assign prod_nxt = PW'($signed({1'b0, radius})) * PW'(unit);

  // round half up, drop the fraction, then clip to the coordinate range
  always_comb begin
    rnd = prod_r + HALF;
    off = rnd[PW-1:cpv_pkg::UNIT_FRAC];
    sum = {{(SW - cpv_pkg::COORD_W){center[cpv_pkg::COORD_W-1]}}, center}
        + {off[OW-1], off};
    if (sum > CMAX) begin
      coord_nxt = CMAX[cpv_pkg::COORD_W-1:0];
      sat_nxt   = 1'b1;
    end else if (sum < CMIN) begin
      coord_nxt = CMIN[cpv_pkg::COORD_W-1:0];
      sat_nxt   = 1'b1;
    end else begin
      coord_nxt = sum[cpv_pkg::COORD_W-1:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      coord_r <= coord_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign coord = coord_r;
  assign sat   = sat_r;

endmodule
`default_nettype wire

>>> design/circle_polygon_vertices_core.sv
// Regular polygon vertex generator: index in, vertex coordinates out.
// Usage:
//   Write radius (0), center_x (1), center_y (2) and number_of_sides (3) on the
//   cfg_ channel while no item is in flight; cfg_ready is always high.
//   Send vertex indices on in_; index 0 gives the centre, 1..n the rim points,
//   anything above n gives the centre with the out_of_range flag in out_tuser.
//   One item is taken per cycle while in_tready is high; one result leaves per item.
//   Each item passes through the input register, 16 divider cells for the
//   phase, one rotator cell per stage, quadrant map, multiply,
//   round/saturate and output register.
//   When the receiver stalls, a skid register catches the one result in transit;
//   once it fills, the whole pipeline holds and in_tready drops.
//   Reset clears every valid bit, empties the output buffer and loads the
//   default registers (radius 1.0, centre at origin, 32 sides).
`timescale 1ns / 1ps
`default_nettype none
module circle_polygon_vertices_core #(
  parameter int MAX_SIDES     = cpv_pkg::MAX_SIDES_DEF,
  parameter int CORDIC_STAGES = cpv_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cpv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_data,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cpv_pkg::IN_DATA_W-1:0]     in_tdata,   // [10:0] vertex_index
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cpv_pkg::OUT_DATA_W-1:0]         out_tdata,  // [15:0] point_x, [31:16] point_y
  output logic [cpv_pkg::OUT_USER_W-1:0]         out_tuser   // [0] out_of_range, [1] saturated
);

  localparam int NCS = (CORDIC_STAGES > cpv_pkg::ATAN_N) ? cpv_pkg::ATAN_N : CORDIC_STAGES;
  localparam int NS_MAXV = (1 << cpv_pkg::NS_W) - 1;
  localparam logic [cpv_pkg::NS_W-1:0] SIDES_CAP =
    cpv_pkg::NS_W'((MAX_SIDES > NS_MAXV) ? NS_MAXV : MAX_SIDES);

  // configuration registers
  logic [cpv_pkg::RAD_W-1:0]          radius_r;
  logic signed [cpv_pkg::COORD_W-1:0] center_x_r;
  logic signed [cpv_pkg::COORD_W-1:0] center_y_r;
  logic [cpv_pkg::NS_W-1:0]           sides_r;
  logic [cpv_pkg::NS_W-1:0]           n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= cpv_pkg::RADIUS_RST;
      center_x_r <= cpv_pkg::CENTER_RST;
      center_y_r <= cpv_pkg::CENTER_RST;
      sides_r    <= cpv_pkg::SIDES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cpv_pkg::REG_RADIUS:   radius_r   <= cfg_data;
        cpv_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        cpv_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        cpv_pkg::REG_SIDES:    sides_r    <= cfg_data[cpv_pkg::NS_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (sides_r > SIDES_CAP) ? SIDES_CAP : sides_r;

  // pipeline advance; holds only while the skid register is occupied
  logic en;
  logic skid_vld_r;
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // input stage
  logic [cpv_pkg::IDX_W-1:0] idx;
  cpv_pkg::cpv_div_t         s0_nxt;
  cpv_pkg::cpv_div_t         div_s [0:cpv_pkg::PH_W];
  logic                      div_v [0:cpv_pkg::PH_W];
  logic                      s0_vld_r;
  cpv_pkg::cpv_div_t         s0_r;

  always_comb begin
    idx            = in_tdata[cpv_pkg::IDX_W-1:0];
    s0_nxt.tag.oor = (idx > n_eff);
    s0_nxt.tag.rim = !(idx > n_eff) && (idx != '0);
    s0_nxt.rem     = idx - cpv_pkg::IDX_W'(1);
    s0_nxt.quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  assign div_s[0] = s0_r;
  assign div_v[0] = s0_vld_r;

  // phase = ((index - 1) * 2^16) / n, one quotient bit per cell
  for (genvar i = 0; i < cpv_pkg::PH_W; i++) begin : g_div
    cpv_div_cell u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (div_v[i]),
      .in_s    (div_s[i]),
      .divisor (n_eff),
      .out_vld (div_v[i+1]),
      .out_s   (div_s[i+1])
    );
  end

  // rotator chain
  cpv_pkg::cpv_rot_t rot_s [0:NCS];
  logic              rot_v [0:NCS];
  cpv_pkg::cpv_div_t dq;
  cpv_pkg::cpv_rot_t rot_in;

  always_comb begin
    dq          = div_s[cpv_pkg::PH_W];
    rot_in.tag  = dq.tag;
    rot_in.quad = dq.quo[cpv_pkg::PH_W-1 -: 2];
    rot_in.x    = cpv_pkg::CORDIC_GAIN;
    rot_in.y    = '0;
    rot_in.z    = {2'b00, dq.quo[cpv_pkg::PH_W-3:0], {(cpv_pkg::Z_W - cpv_pkg::PH_W){1'b0}}};
  end
  assign rot_s[0] = rot_in;
  assign rot_v[0] = div_v[cpv_pkg::PH_W];

  for (genvar k = 0; k < NCS; k++) begin : g_rot
    cpv_cordic_cell #(.STAGE(k)) u_rot (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (rot_v[k]),
      .in_s    (rot_s[k]),
      .out_vld (rot_v[k+1]),
      .out_s   (rot_s[k+1])
    );
  end

  // quadrant map
  cpv_pkg::cpv_rot_t                rq;
  logic signed [cpv_pkg::XY_W-1:0]  c_nxt;
  logic signed [cpv_pkg::XY_W-1:0]  s_nxt;
  logic signed [cpv_pkg::XY_W-1:0]  c_r;
  logic signed [cpv_pkg::XY_W-1:0]  s_r;
  cpv_pkg::cpv_tag_t                map_tag_r;
  logic                             map_vld_r;

  always_comb begin
    rq = rot_s[NCS];
    case (rq.quad)
      cpv_pkg::QUAD_I: begin
        c_nxt = rq.x;
        s_nxt = rq.y;
      end
      cpv_pkg::QUAD_II: begin
        c_nxt = -rq.y;
        s_nxt = rq.x;
      end
      cpv_pkg::QUAD_III: begin
        c_nxt = -rq.x;
        s_nxt = -rq.y;
      end
      default: begin
        c_nxt = rq.y;
        s_nxt = -rq.x;
      end
    endcase
  end

  // tag follows the two place stages
  cpv_pkg::cpv_tag_t mul_tag_r;
  cpv_pkg::cpv_tag_t plc_tag_r;
  logic              mul_vld_r;
  logic              plc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      plc_vld_r <= 1'b0;
    end else if (en) begin
      map_vld_r <= rot_v[NCS];
      mul_vld_r <= map_vld_r;
      plc_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r       <= c_nxt;
      s_r       <= s_nxt;
      map_tag_r <= rq.tag;
      mul_tag_r <= map_tag_r;
      plc_tag_r <= mul_tag_r;
    end
  end

  logic signed [cpv_pkg::COORD_W-1:0] px;
  logic signed [cpv_pkg::COORD_W-1:0] py;
  logic                               sat_x;
  logic                               sat_y;

  cpv_place u_place_x (
    .clk    (clk),
    .en     (en),
    .unit   (c_r),
    .radius (radius_r),
    .center (center_x_r),
    .coord  (px),
    .sat    (sat_x)
  );

  cpv_place u_place_y (
    .clk    (clk),
    .en     (en),
    .unit   (s_r),
    .radius (radius_r),
    .center (center_y_r),
    .coord  (py),
    .sat    (sat_y)
  );

  // centre for index zero and out-of-range indices
  cpv_pkg::cpv_res_t res;
  always_comb begin
    res.px  = plc_tag_r.rim ? px : center_x_r;
    res.py  = plc_tag_r.rim ? py : center_y_r;
    res.oor = plc_tag_r.oor;
    res.sat = plc_tag_r.rim && (sat_x || sat_y);
  end

  // output register with skid
  logic              out_vld_r;
  cpv_pkg::cpv_res_t out_r;
  cpv_pkg::cpv_res_t skid_r;
  logic              take;
  logic              push;

  assign take = out_vld_r && out_tready;
  assign push = en && plc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !take) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_vld_r && !take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.py, out_r.px};
  assign out_tuser  = {out_r.sat, out_r.oor};

  // the skid register is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register holds a transfer while the output register is empty");

  // back-pressure reaches the input only after a stalled result
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_vld_r && !out_tready))
    else $error("in_tready dropped without a stalled result");

  // an out-of-range index returns the centre, never a clipped rim point
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("out_of_range and saturated raised together");

endmodule
`default_nettype wire
